// ===== design/amalm_pkg.sv =====
`timescale 1ns / 1ps
package amalm_pkg;

   localparam int SAMPLE_BITS      = 12;
   localparam int WINDOW_BITS      = 16;
   localparam int SAMPLE_PORT_BITS = 12;
   localparam int WIN_REG_BITS     = 16;
   localparam int LOOP_BITS        = 8;
   localparam int GAIN_BITS        = 32;
   localparam int VOLT_BITS        = 24;
   localparam int ZERO_BITS        = 12;
   localparam int DATA_BITS        = 32;
   localparam int ADDR_BITS        = 4;
   localparam int REG_INDEX_BITS   = ADDR_BITS - 2;

   localparam int RAW_BITS     = SAMPLE_BITS + WINDOW_BITS;
   localparam int ABS_BITS     = RAW_BITS + LOOP_BITS;
   localparam int DIVISOR_BITS = WINDOW_BITS + LOOP_BITS;
   localparam int SCALE_SHIFT  = 16;
   localparam int NUM_BITS     = ABS_BITS + GAIN_BITS - SCALE_SHIFT;
   localparam int MUL_BITS     = 32;
   localparam int WIDE_BITS    = 3 * MUL_BITS;
   localparam int STEP_BITS    = $clog2(NUM_BITS + 1);

   localparam logic [REG_INDEX_BITS-1:0] REG_WINDOW = REG_INDEX_BITS'(0);
   localparam logic [REG_INDEX_BITS-1:0] REG_LOOPS  = REG_INDEX_BITS'(1);
   localparam logic [REG_INDEX_BITS-1:0] REG_GAIN   = REG_INDEX_BITS'(2);

   localparam logic [WIN_REG_BITS-1:0] WINDOW_RESET = WIN_REG_BITS'(1000);
   localparam logic [LOOP_BITS-1:0]    LOOPS_RESET  = LOOP_BITS'(1);
   localparam logic [GAIN_BITS-1:0]    GAIN_RESET   = GAIN_BITS'(32'h0100_0000);

   typedef struct packed {
      logic [WIN_REG_BITS-1:0] samples_per_window;
      logic [LOOP_BITS-1:0]    loop_count;
      logic [GAIN_BITS-1:0]    gain;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic mul_lo;
      logic mul_hi;
      logic load_scale;
      logic div_step;
      logic zero_done;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic rect;
      logic win_end;
      logic last_round;
   } status_type;

   // zero length acts as a one-sample window
   function automatic logic [WINDOW_BITS-1:0] eff_window(input cfg_type cfg);
      logic [WINDOW_BITS-1:0] w;
      w = WINDOW_BITS'(cfg.samples_per_window);
      return (w == '0) ? WINDOW_BITS'(1) : w;
   endfunction

   function automatic logic [LOOP_BITS-1:0] eff_loops(input cfg_type cfg);
      return (cfg.loop_count == '0) ? LOOP_BITS'(1) : cfg.loop_count;
   endfunction

endpackage

// ===== design/ac_mean_abs_level_meter_core.sv =====
`timescale 1ns / 1ps
// channel  direction  ports                                   beat moves
// req      in         req_valid, req_ready, req_sample        one adc sample
// rsp      out        rsp_valid, rsp_ready, rsp_voltage_q8,   one voltage reading
//                     rsp_zero_point
// csr      in/out     psel, penable, pwrite, paddr, pwdata,   one register access
//                     prdata, pready
//
// samples inside a window stream at one per clock while no window end is in work
// a zero-point window end runs: accept, 52 divider steps, zero load
// a measurement end runs: accept, two 32x32 multiply passes,
// divider load, 52 divider steps, a closing divider state and the output write
// the output write waits while the previous reading is still pending on rsp
// synchronous reset restores register defaults and clears the measurement state
module ac_mean_abs_level_meter_core
   import amalm_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [SAMPLE_PORT_BITS-1:0] req_sample,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [VOLT_BITS-1:0]        rsp_voltage_q8,
   output logic [ZERO_BITS-1:0]        rsp_zero_point,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ADDR_BITS-1:0]        paddr,
   input  logic [DATA_BITS-1:0]        pwdata,
   output logic [DATA_BITS-1:0]        prdata,
   output logic                        pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   amalm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   amalm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   amalm_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (cmd),
      .req_sample     (req_sample),
      .status         (status),
      .rsp_voltage_q8 (rsp_voltage_q8),
      .rsp_zero_point (rsp_zero_point)
   );

endmodule

// ===== design/amalm_csr.sv =====
`timescale 1ns / 1ps
module amalm_csr
   import amalm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready,
   output cfg_type              cfg
);

   cfg_type                   cfg_ff;
   cfg_type                   cfg_in;
   logic [REG_INDEX_BITS-1:0] index;
   logic                      wr;

   assign index  = paddr[ADDR_BITS-1:2];
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (index)
            REG_WINDOW: cfg_in.samples_per_window = pwdata[WIN_REG_BITS-1:0];
            REG_LOOPS:  cfg_in.loop_count         = pwdata[LOOP_BITS-1:0];
            REG_GAIN:   cfg_in.gain               = pwdata[GAIN_BITS-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_WINDOW: prdata = DATA_BITS'(cfg_ff.samples_per_window);
         REG_LOOPS:  prdata = DATA_BITS'(cfg_ff.loop_count);
         REG_GAIN:   prdata = DATA_BITS'(cfg_ff.gain);
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.samples_per_window <= WINDOW_RESET;
         cfg_ff.loop_count         <= LOOPS_RESET;
         cfg_ff.gain               <= GAIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== design/amalm_dp.sv =====
`timescale 1ns / 1ps
module amalm_dp
   import amalm_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  cfg_type                     cfg,
   input  cmd_type                     cmd,
   input  logic [SAMPLE_PORT_BITS-1:0] req_sample,
   output status_type                  status,
   output logic [VOLT_BITS-1:0]        rsp_voltage_q8,
   output logic [ZERO_BITS-1:0]        rsp_zero_point
);

   // measurement state
   logic                      rect_ff, rect_in;
   logic [WINDOW_BITS-1:0]    pos_ff, pos_in;
   logic [LOOP_BITS-1:0]      round_ff, round_in;
   logic [RAW_BITS-1:0]       raw_ff, raw_in;
   logic [SAMPLE_BITS-1:0]    zero_ff, zero_in;
   logic [ABS_BITS-1:0]       abs_ff, abs_in;

   // scaling and division
   logic [2*MUL_BITS-1:0]     mul_ff, mul_in;
   logic [2*MUL_BITS-1:0]     acc_ff, acc_in;
   logic [NUM_BITS-1:0]       num_ff, num_in;
   logic [DIVISOR_BITS-1:0]   rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]   div_ff, div_in;
   logic [VOLT_BITS-1:0]      volt_ff, volt_in;
   logic [ZERO_BITS-1:0]      zout_ff, zout_in;

   logic [SAMPLE_BITS-1:0]    s;
   logic [WINDOW_BITS-1:0]    w;
   logic [LOOP_BITS-1:0]      l;
   logic [RAW_BITS-1:0]       raw_next;
   logic [SAMPLE_BITS-1:0]    abs_diff;
   logic [ABS_BITS-1:0]       abs_next;
   logic [2*MUL_BITS-1:0]     abs_wide;
   logic [MUL_BITS-1:0]       mul_a;
   logic [2*MUL_BITS-1:0]     mul_prod;
   logic [WIDE_BITS-1:0]      wide;
   logic [DIVISOR_BITS:0]     trial;
   logic [DIVISOR_BITS:0]     trial_sub;
   logic                      q_bit;
   logic                      sat;

   assign s = SAMPLE_BITS'(req_sample);
   assign w = eff_window(cfg);
   assign l = eff_loops(cfg);

   assign status.rect       = rect_ff;
   assign status.win_end    = ({1'b0, pos_ff} + (WINDOW_BITS + 1)'(1)) >= {1'b0, w};
   assign status.last_round = ({1'b0, round_ff} + (LOOP_BITS + 1)'(1)) >= {1'b0, l};

   assign raw_next = raw_ff + RAW_BITS'(s);
   assign abs_diff = (s >= zero_ff) ? (s - zero_ff) : (zero_ff - s);
   assign abs_next = abs_ff + ABS_BITS'(abs_diff);

   // 36 x 32 product as two 32 x 32 passes
   assign abs_wide = (2*MUL_BITS)'(abs_ff);
   assign mul_a    = cmd.mul_hi ? abs_wide[2*MUL_BITS-1:MUL_BITS] : abs_wide[MUL_BITS-1:0];
   assign mul_prod = (2*MUL_BITS)'(mul_a) * (2*MUL_BITS)'(cfg.gain);
   assign wide     = WIDE_BITS'(acc_ff) + (WIDE_BITS'(mul_ff) << MUL_BITS);

   // restoring divider, one quotient bit per step
   assign trial     = {rem_ff, num_ff[NUM_BITS-1]};
   assign trial_sub = trial - {1'b0, div_ff};
   assign q_bit     = trial >= {1'b0, div_ff};
   assign sat       = |num_ff[NUM_BITS-1:VOLT_BITS];

   always_comb begin
      rect_in  = rect_ff;
      pos_in   = pos_ff;
      round_in = round_ff;
      raw_in   = raw_ff;
      zero_in  = zero_ff;
      abs_in   = abs_ff;
      mul_in   = mul_ff;
      acc_in   = acc_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      volt_in  = volt_ff;
      zout_in  = zout_ff;
      if (cmd.accept) begin
         if (!rect_ff) begin
            if (status.win_end) begin
               raw_in  = '0;
               pos_in  = '0;
               rect_in = 1'b1;
               num_in  = NUM_BITS'(raw_next);
               rem_in  = '0;
               div_in  = DIVISOR_BITS'(w);
            end else begin
               raw_in = raw_next;
               pos_in = pos_ff + WINDOW_BITS'(1);
            end
         end else begin
            abs_in = abs_next;
            if (status.win_end) begin
               pos_in  = '0;
               rect_in = 1'b0;
               if (status.last_round) begin
                  round_in = '0;
               end else begin
                  round_in = round_ff + LOOP_BITS'(1);
               end
            end else begin
               pos_in = pos_ff + WINDOW_BITS'(1);
            end
         end
      end
      if (cmd.mul_lo) begin
         mul_in = mul_prod;
      end
      if (cmd.mul_hi) begin
         acc_in = mul_ff;
         mul_in = mul_prod;
         abs_in = '0;
      end
      if (cmd.load_scale) begin
         num_in = wide[SCALE_SHIFT +: NUM_BITS];
         rem_in = '0;
         div_in = DIVISOR_BITS'(w) * DIVISOR_BITS'(l);
      end
      if (cmd.div_step) begin
         rem_in = q_bit ? trial_sub[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
         num_in = {num_ff[NUM_BITS-2:0], q_bit};
      end
      if (cmd.zero_done) begin
         zero_in = num_ff[SAMPLE_BITS-1:0];
      end
      if (cmd.emit) begin
         volt_in = sat ? '1 : num_ff[VOLT_BITS-1:0];
         zout_in = ZERO_BITS'(zero_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_ff  <= 1'b0;
         pos_ff   <= '0;
         round_ff <= '0;
         raw_ff   <= '0;
         zero_ff  <= '0;
         abs_ff   <= '0;
      end else begin
         rect_ff  <= rect_in;
         pos_ff   <= pos_in;
         round_ff <= round_in;
         raw_ff   <= raw_in;
         zero_ff  <= zero_in;
         abs_ff   <= abs_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_ff  <= mul_in;
      acc_ff  <= acc_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      volt_ff <= volt_in;
      zout_ff <= zout_in;
   end

   assign rsp_voltage_q8 = volt_ff;
   assign rsp_zero_point = zout_ff;

endmodule

// ===== design/amalm_ctrl.sv =====
`timescale 1ns / 1ps
module amalm_ctrl
   import amalm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ZDIV   = 3'd1;
   localparam logic [2:0] ST_MUL_LO = 3'd2;
   localparam logic [2:0] ST_MUL_HI = 3'd3;
   localparam logic [2:0] ST_LOAD   = 3'd4;
   localparam logic [2:0] ST_SDIV   = 3'd5;
   localparam logic [2:0] ST_EMIT   = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic [STEP_BITS-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 steps_done;

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign steps_done = (cnt_ff == STEP_BITS'(NUM_BITS));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               cnt_in     = '0;
               if (!status.rect && status.win_end) begin
                  state_in = ST_ZDIV;
               end else if (status.rect && status.win_end && status.last_round) begin
                  state_in = ST_MUL_LO;
               end
            end
         end
         ST_ZDIV: begin
            if (steps_done) begin
               cmd.zero_done = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.div_step = 1'b1;
               cnt_in       = cnt_ff + STEP_BITS'(1);
            end
         end
         ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load_scale = 1'b1;
            cnt_in         = '0;
            state_in       = ST_SDIV;
         end
         ST_SDIV: begin
            if (steps_done) begin
               state_in = ST_EMIT;
            end else begin
               cmd.div_step = 1'b1;
               cnt_in       = cnt_ff + STEP_BITS'(1);
            end
         end
         ST_EMIT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");

   a_last_sample_scales: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && status.rect && status.win_end && status.last_round)
      |=> (state_ff == ST_MUL_LO))
      else $error("measurement end did not start scaling");

   a_mul_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_LO) |=> (state_ff == ST_MUL_HI))
      else $error("multiply passes out of order");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (cnt_ff < STEP_BITS'(NUM_BITS)))
      else $error("divider stepped past its width");
`endif

endmodule

// ===== test/ac_mean_abs_level_meter_core_tb.sv =====
`timescale 1ns / 1ps
module ac_mean_abs_level_meter_core_tb;
   import amalm_pkg::*;

   localparam int RANDOM_ITEMS  = 1650;
   localparam int SETTLE_CYCLES = 120;
   localparam int HOLD_CYCLES   = 600;
   localparam int STALL_LIMIT   = 4000;

   typedef struct {
      logic [VOLT_BITS-1:0] volt;
      logic [ZERO_BITS-1:0] zero;
   } reading_type;

   logic                        clock;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [SAMPLE_PORT_BITS-1:0] req_sample = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [VOLT_BITS-1:0]        rsp_voltage_q8;
   logic [ZERO_BITS-1:0]        rsp_zero_point;
   logic                        psel = 1'b0;
   logic                        penable = 1'b0;
   logic                        pwrite = 1'b0;
   logic [ADDR_BITS-1:0]        paddr = '0;
   logic [DATA_BITS-1:0]        pwdata = '0;
   logic [DATA_BITS-1:0]        prdata;
   logic                        pready;

   // shadow of the configuration registers
   logic [WIN_REG_BITS-1:0] cfg_window = WINDOW_RESET;
   logic [LOOP_BITS-1:0]    cfg_loops  = LOOPS_RESET;
   logic [GAIN_BITS-1:0]    cfg_gain   = GAIN_RESET;

   // shadow of the measurement state
   logic                   in_rect    = 1'b0;
   logic [WINDOW_BITS-1:0] win_pos    = '0;
   logic [LOOP_BITS-1:0]   round_idx  = '0;
   logic [RAW_BITS-1:0]    raw_acc    = '0;
   logic [ZERO_BITS-1:0]   zero_level = '0;
   logic [ABS_BITS-1:0]    abs_acc    = '0;

   reading_type expected_readings[$];
   int  mismatch_count = 0;
   int  idle_cycles = 0;
   int  req_max_gap = 16;
   int  rsp_max_gap = 16;
   bit  hold_rsp = 1'b0;

   ac_mean_abs_level_meter_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_sample(req_sample),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_voltage_q8(rsp_voltage_q8), .rsp_zero_point(rsp_zero_point),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // advance the meter by one accepted sample
   task automatic meter_predict(input logic [SAMPLE_PORT_BITS-1:0] raw);
      logic [SAMPLE_BITS-1:0] s;
      logic [WINDOW_BITS-1:0] w;
      logic [LOOP_BITS-1:0]   l;
      logic                   win_done;
      logic [RAW_BITS-1:0]    mean;
      logic [SAMPLE_BITS-1:0] abs_diff;
      logic [67:0]            prod;
      logic [39:0]            divisor;
      logic [67:0]            quo;
      reading_type            r;
      s = raw[SAMPLE_BITS-1:0];
      w = (cfg_window[WINDOW_BITS-1:0] == '0) ? WINDOW_BITS'(1) : cfg_window[WINDOW_BITS-1:0];
      l = (cfg_loops == '0) ? LOOP_BITS'(1) : cfg_loops;
      win_done = ({1'b0, win_pos} + 17'd1) >= {1'b0, w};
      if (!in_rect) begin
         raw_acc = raw_acc + RAW_BITS'(s);
         if (win_done) begin
            mean = raw_acc / RAW_BITS'(w);
            zero_level = mean[ZERO_BITS-1:0];
            raw_acc = '0;
            win_pos = '0;
            in_rect = 1'b1;
         end else begin
            win_pos = win_pos + 1'b1;
         end
      end else begin
         abs_diff = (s >= zero_level) ? s - zero_level : zero_level - s;
         abs_acc = abs_acc + ABS_BITS'(abs_diff);
         if (!win_done) begin
            win_pos = win_pos + 1'b1;
         end else begin
            win_pos = '0;
            in_rect = 1'b0;
            if (({1'b0, round_idx} + 9'd1) < {1'b0, l}) begin
               round_idx = round_idx + 1'b1;
            end else begin
               prod = 68'(abs_acc) * 68'(cfg_gain);
               divisor = (40'(w) * 40'(l)) << SCALE_SHIFT;
               quo = prod / 68'(divisor);
               r.volt = (quo > 68'hFF_FFFF) ? 24'hFF_FFFF : quo[VOLT_BITS-1:0];
               r.zero = zero_level;
               expected_readings.push_back(r);
               abs_acc = '0;
               round_idx = '0;
            end
         end
      end
   endtask

   task automatic send_sample(input logic [SAMPLE_PORT_BITS-1:0] s);
      int gap;
      gap = (req_max_gap == 0) ? 0 : $urandom_range(0, req_max_gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (!req_ready);
      meter_predict(s);
   endtask

   task automatic csr_write(input logic [REG_INDEX_BITS-1:0] idx,
                            input logic [DATA_BITS-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_WINDOW: cfg_window = value[WIN_REG_BITS-1:0];
         REG_LOOPS:  cfg_loops = value[LOOP_BITS-1:0];
         REG_GAIN:   cfg_gain = value[GAIN_BITS-1:0];
         default: ;
      endcase
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic csr_check(input logic [REG_INDEX_BITS-1:0] idx);
      logic [DATA_BITS-1:0] want;
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_WINDOW: want = DATA_BITS'(cfg_window);
         REG_LOOPS:  want = DATA_BITS'(cfg_loops);
         REG_GAIN:   want = DATA_BITS'(cfg_gain);
         default:    want = '0;
      endcase
      if (prdata !== want) begin
         $display("%0t: register %0d readback expected %h actual %h", $time, idx, want, prdata);
         mismatch_count++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // sender stops until every reading is out and the block has gone quiet
   task automatic wait_meter_idle();
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_PORT_BITS-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return ($urandom_range(0, 1) == 0) ? 12'd0 : 12'd4095;
         1, 2, 3: return 12'($urandom_range(1500, 2600));
         default: return 12'($urandom);
      endcase
   endfunction

   function automatic logic [GAIN_BITS-1:0] pick_gain();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 32'hFFFF_FFFF;
         2:       return GAIN_RESET;
         3:       return 32'($urandom_range(0, 65535));
         default: return 32'($urandom);
      endcase
   endfunction

   task automatic test_register_access();
      csr_check(REG_WINDOW);
      csr_check(REG_LOOPS);
      csr_check(REG_GAIN);
      csr_write(REG_WINDOW, 32'($urandom));
      csr_write(REG_LOOPS, 32'($urandom));
      csr_write(REG_GAIN, 32'($urandom));
      csr_check(REG_WINDOW);
      csr_check(REG_LOOPS);
      csr_check(REG_GAIN);
   endtask

   task automatic test_short_windows();
      // zero length and zero loop count both act as one
      csr_write(REG_WINDOW, {16'($urandom), 16'h0000});
      csr_write(REG_LOOPS, {24'($urandom), 8'h00});
      csr_write(REG_GAIN, GAIN_RESET);
      csr_check(REG_WINDOW);
      send_sample(12'd0);
      send_sample(12'd4095);
      send_sample(12'd4095);
      send_sample(12'd0);
      send_sample(12'd2048);
      send_sample(12'd2048);
      wait_meter_idle();
      csr_write(REG_WINDOW, 32'd1);
      csr_write(REG_LOOPS, 32'd2);
      send_sample(12'd0);
      send_sample(12'd4095);
      send_sample(12'd4095);
      send_sample(12'd0);
      wait_meter_idle();
   endtask

   task automatic test_saturation();
      csr_write(REG_WINDOW, 32'd1);
      csr_write(REG_LOOPS, 32'd1);
      csr_write(REG_GAIN, 32'hFFFF_FFFF);
      send_sample(12'd0);
      send_sample(12'd4095);
      wait_meter_idle();
      // zero gain reads as zero volts
      csr_write(REG_GAIN, 32'd0);
      send_sample(12'd100);
      send_sample(12'd3000);
      wait_meter_idle();
   endtask

   task automatic test_window_change();
      csr_write(REG_WINDOW, 32'h0000_FFFF);
      csr_write(REG_LOOPS, 32'h0000_00FF);
      csr_write(REG_GAIN, pick_gain());
      send_sample(12'd4095);
      send_sample(12'd4095);
      send_sample(12'd0);
      wait_meter_idle();
      // shorter window than the position already reached ends it at once
      csr_write(REG_WINDOW, 32'd2);
      send_sample(12'd4095);
      send_sample(12'd17);
      send_sample(12'd3900);
      wait_meter_idle();
      csr_write(REG_LOOPS, 32'd1);
      send_sample(12'd1000);
      send_sample(12'd3000);
      send_sample(12'd0);
      send_sample(12'd4095);
      wait_meter_idle();
   endtask

   task automatic test_backpressure();
      csr_write(REG_WINDOW, 32'd1);
      csr_write(REG_LOOPS, 32'd1);
      csr_write(REG_GAIN, GAIN_RESET);
      req_max_gap = 0;
      hold_rsp = 1'b1;
      repeat (24) send_sample(pick_sample());
      req_max_gap = 16;
      wait_meter_idle();
   endtask

   task automatic test_random_measurements();
      int sent;
      int w;
      int l;
      int count;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_meter_idle();
         case ($urandom_range(0, 19))
            0:       w = 0;
            1:       w = $urandom_range(32, 64);
            2, 3:    w = $urandom_range(7, 24);
            default: w = $urandom_range(1, 6);
         endcase
         if ($urandom_range(0, 9) == 0) l = 0;
         else if (w <= 2 && $urandom_range(0, 5) == 0) l = $urandom_range(8, 12);
         else l = $urandom_range(1, 4);
         csr_write(REG_WINDOW, {16'($urandom), 16'(w)});
         csr_write(REG_LOOPS, {24'($urandom), 8'(l)});
         csr_write(REG_GAIN, pick_gain());
         req_max_gap = ($urandom_range(0, 4) == 0) ? 0 : 16;
         rsp_max_gap = ($urandom_range(0, 4) == 0) ? 0 : 16;
         count = 2 * ((w == 0) ? 1 : w) * ((l == 0) ? 1 : l);
         if (count <= 32) count = count * $urandom_range(1, 4);
         // a broken measurement runs on into the next setting
         if ($urandom_range(0, 3) == 0) count = count + $urandom_range(1, 5);
         repeat (count) send_sample(pick_sample());
         sent = sent + count;
      end
      req_max_gap = 16;
      rsp_max_gap = 16;
   endtask

   // receiver side
   initial begin
      int gap;
      forever begin
         if (hold_rsp) begin
            gap = HOLD_CYCLES;
            hold_rsp = 1'b0;
         end else begin
            gap = (rsp_max_gap == 0) ? 0 : $urandom_range(0, rsp_max_gap);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_readings.size() == 0) begin
            $display("%0t: unexpected beat voltage_q8 %0d zero_point %0d",
                     $time, rsp_voltage_q8, rsp_zero_point);
            mismatch_count++;
         end else begin
            want = expected_readings.pop_front();
            if (rsp_voltage_q8 !== want.volt) begin
               $display("%0t: voltage_q8 expected %0d actual %0d",
                        $time, want.volt, rsp_voltage_q8);
               mismatch_count++;
            end
            if (rsp_zero_point !== want.zero) begin
               $display("%0t: zero_point expected %0d actual %0d",
                        $time, want.zero, rsp_zero_point);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (psel && penable && pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_register_access();
      test_short_windows();
      test_saturation();
      test_window_change();
      test_backpressure();
      test_random_measurements();
      wait_meter_idle();
      if (mismatch_count == 0 && expected_readings.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
